### rtl/assert_macros.svh
// Assertion macros used by the heap top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Invariant checked on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant failed");

`endif

### rtl/iemh_pkg.sv
// Types, constants and codes of the indexed event min-heap.
package iemh_pkg;

    localparam int ID_W          = 11;
    localparam int IN_KEY_W      = 32;
    localparam int TOL_W         = 8;
    localparam int OCC_W         = 12;
    localparam int EVENT_SLOTS_D = 2048;
    localparam int KEY_WIDTH_D   = 32;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_DUP   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED1,
        S_RED2,
        S_PUSH_HEAP,
        S_PUSH_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_PLACE,
        S_POP_RD,
        S_POP_GET,
        S_DN_RD,
        S_DN_SEL,
        S_DN_CMP
    } state_t;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [ID_W-1:0]            event_req;
        logic signed [IN_KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]            popped_event;
        logic signed [IN_KEY_W-1:0] popped_key;
        logic [1:0]                 status;
        logic [OCC_W-1:0]           occupancy;
    } out_item_t;

endpackage

### rtl/iemh_heap_mem.sv
// Heap entry memory: one write port, two registered read ports.
module iemh_heap_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 43
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### rtl/iemh_slot_mem.sv
// Position table: heap slot of each event id, one write and one registered read port.
module iemh_slot_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/indexed_event_min_heap_top.sv
// Indexed event min-heap: sequencer, compare logic and the two memories.
// Push: reduce the id, read slot and heap entry, climb until the parent ranks first; a duplicate
// or a push into a full heap is ignored. Pop: an empty heap reports empty, the last item needs
// no sift, else the last entry sifts down. Clear and no-op end after the id reduction.
// busy drops in the cycle of the done strobe, where the next item can be taken.
// Reset empties the heap at once (fill count zero) and sets the tie tolerance to zero.
module indexed_event_min_heap_top #(
    parameter int EVENT_SLOTS = iemh_pkg::EVENT_SLOTS_D,
    parameter int KEY_WIDTH   = iemh_pkg::KEY_WIDTH_D
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  iemh_pkg::in_item_t             cmd,
    output logic                           done,
    output iemh_pkg::out_item_t            result,
    input  logic                           cfg_we,
    input  logic [iemh_pkg::TOL_W-1:0]     cfg_data
);

    import iemh_pkg::*;

    `include "assert_macros.svh"

    localparam int AW         = $clog2(EVENT_SLOTS);
    localparam int CW         = $clog2(EVENT_SLOTS + 1);
    localparam int PW         = AW + 2;
    localparam int KW         = KEY_WIDTH;
    localparam int KW1        = KEY_WIDTH + 1;
    localparam int ENT_W      = ID_W + KEY_WIDTH;
    localparam int SLOT_DEPTH = (EVENT_SLOTS < (1 << ID_W)) ? EVENT_SLOTS : (1 << ID_W);
    localparam int SW         = $clog2(SLOT_DEPTH);
    localparam int RED_SH     = 22;
    localparam int RED_M      = (1 << RED_SH) / EVENT_SLOTS;
    localparam int PROD_W     = RED_SH + 12;
    localparam logic [31:0] NV = 32'(EVENT_SLOTS);

    function automatic logic ev_less(
        input logic [ENT_W-1:0] a,
        input logic [ENT_W-1:0] b,
        input logic [TOL_W-1:0] tol
    );
        logic signed [KW-1:0]  ka;
        logic signed [KW-1:0]  kb;
        logic signed [KW1-1:0] d;
        logic [KW1-1:0]        mag;
        ka  = $signed(a[KW-1:0]);
        kb  = $signed(b[KW-1:0]);
        d   = KW1'(ka) - KW1'(kb);
        mag = d[KW1-1] ? KW1'(-d) : KW1'(d);
        if (mag > KW1'(tol))
        begin
            return ka < kb;
        end
        return !a[KW] && b[KW];
    endfunction

    state_t state_reg, state_next;

    logic [1:0]       op_reg;
    logic [ID_W-1:0]  ev_raw_reg;
    logic [11:0]      q_reg;
    logic [ENT_W-1:0] item_reg;
    logic [ENT_W-1:0] child_reg;
    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    cpos_reg;
    logic [CW-1:0]    fill_reg;
    logic [TOL_W-1:0] tol_reg;
    logic             done_reg;
    logic [ID_W-1:0]  res_ev_reg;
    logic [KW-1:0]    res_key_reg;
    logic [1:0]       res_status_reg;

    logic             hp_we, hp_re;
    logic [AW-1:0]    hp_wa, hp_ra, hp_rb;
    logic [ENT_W-1:0] hp_wd, hp_da, hp_db;
    logic             sl_we, sl_re;
    logic [SW-1:0]    sl_wa, sl_ra;
    logic [AW-1:0]    sl_wd, sl_rd;

    logic [PROD_W-1:0] prod;
    logic [31:0]       r0, r1;
    logic [ID_W-1:0]   ev_red;
    logic              accept, fin, present, full, up_stop, dn_stop, use_b;
    logic [AW-1:0]     parent;
    logic [AW:0]       c_w, c1_w;
    logic              c_in, c1_in;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    assign prod   = PROD_W'(ev_raw_reg) * PROD_W'(RED_M);
    assign r0     = 32'(ev_raw_reg) - 32'(q_reg) * NV;
    assign r1     = (r0 >= NV) ? (r0 - NV) : r0;
    assign ev_red = ID_W'(r1);

    assign present = (CW'(sl_rd) < fill_reg)
                     && (hp_da[ENT_W-1 -: ID_W] == item_reg[ENT_W-1 -: ID_W]);
    assign full    = (fill_reg >= CW'(EVENT_SLOTS));
    assign parent  = AW'((pos_reg - AW'(1)) >> 1);
    assign up_stop = ev_less(hp_da, item_reg, tol_reg);
    assign c_w     = {pos_reg, 1'b1};
    assign c1_w    = c_w + (AW+1)'(1);
    assign c_in    = (PW'(c_w) < PW'(fill_reg));
    assign c1_in   = (PW'(c1_w) < PW'(fill_reg));
    assign use_b   = c1_in && ev_less(hp_db, hp_da, tol_reg);
    assign dn_stop = !ev_less(child_reg, item_reg, tol_reg);

    iemh_heap_mem #(.DEPTH(EVENT_SLOTS), .AW(AW), .DW(ENT_W)) u_heap (
        .clk     (clk),
        .we      (hp_we),
        .waddr   (hp_wa),
        .wdata   (hp_wd),
        .re      (hp_re),
        .raddr_a (hp_ra),
        .raddr_b (hp_rb),
        .rdata_a (hp_da),
        .rdata_b (hp_db)
    );

    iemh_slot_mem #(.DEPTH(SLOT_DEPTH), .AW(SW), .DW(AW)) u_slot (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_wa),
        .wdata (sl_wd),
        .re    (sl_re),
        .raddr (sl_ra),
        .rdata (sl_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (accept) state_next = S_RED1;
            S_RED1:      state_next = S_RED2;
            S_RED2:
            begin
                if (op_reg == OP_PUSH)
                    state_next = S_PUSH_HEAP;
                else if (op_reg == OP_POP && fill_reg != '0)
                    state_next = S_POP_RD;
                else
                    state_next = S_IDLE;
            end
            S_PUSH_HEAP: state_next = S_PUSH_CHK;
            S_PUSH_CHK:
            begin
                priority if (present || full)
                    state_next = S_IDLE;
                else if (fill_reg == '0)
                    state_next = S_PLACE;
                else
                    state_next = S_UP_RD;
            end
            S_UP_RD:     state_next = S_UP_CMP;
            S_UP_CMP:
            begin
                priority if (up_stop)
                    state_next = S_IDLE;
                else if (parent == '0)
                    state_next = S_PLACE;
                else
                    state_next = S_UP_RD;
            end
            S_PLACE:     state_next = S_IDLE;
            S_POP_RD:    state_next = S_POP_GET;
            S_POP_GET:   state_next = (fill_reg == '0) ? S_IDLE : S_DN_RD;
            S_DN_RD:     state_next = c_in ? S_DN_SEL : S_PLACE;
            S_DN_SEL:    state_next = S_DN_CMP;
            S_DN_CMP:    state_next = dn_stop ? S_PLACE : S_DN_RD;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        hp_we = 1'b0;
        hp_wa = pos_reg;
        hp_wd = item_reg;
        hp_re = 1'b0;
        hp_ra = '0;
        hp_rb = '0;
        sl_we = 1'b0;
        sl_wa = SW'(item_reg[ENT_W-1 -: ID_W]);
        sl_wd = pos_reg;
        sl_re = 1'b0;
        sl_ra = SW'(ev_red);
        fin   = 1'b0;
        unique case (state_reg)
            S_RED2:
            begin
                sl_re = (op_reg == OP_PUSH);
                fin   = !(op_reg == OP_PUSH) && !(op_reg == OP_POP && fill_reg != '0);
            end
            S_PUSH_HEAP:
            begin
                hp_re = 1'b1;
                hp_ra = sl_rd;
            end
            S_PUSH_CHK:  fin = present || full;
            S_UP_RD:
            begin
                hp_re = 1'b1;
                hp_ra = parent;
            end
            S_UP_CMP:
            begin
                hp_we = 1'b1;
                sl_we = 1'b1;
                fin   = up_stop;
                if (!up_stop)
                begin
                    hp_wd = hp_da;
                    sl_wa = SW'(hp_da[ENT_W-1 -: ID_W]);
                end
            end
            S_PLACE:
            begin
                hp_we = 1'b1;
                sl_we = 1'b1;
                fin   = 1'b1;
            end
            S_POP_RD:
            begin
                hp_re = 1'b1;
                hp_rb = AW'(fill_reg);
            end
            S_POP_GET:   fin = (fill_reg == '0);
            S_DN_RD:
            begin
                hp_re = c_in;
                hp_ra = AW'(c_w);
                hp_rb = AW'(c1_w);
            end
            S_DN_CMP:
            begin
                hp_we = !dn_stop;
                sl_we = !dn_stop;
                hp_wd = child_reg;
                sl_wa = SW'(child_reg[ENT_W-1 -: ID_W]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            tol_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (cfg_we)
                tol_reg <= cfg_data;
            if (state_reg == S_RED2)
            begin
                if (op_reg == OP_CLEAR)
                    fill_reg <= '0;
                else if (op_reg == OP_POP && fill_reg != '0)
                    fill_reg <= fill_reg - CW'(1);
            end
            if (state_reg == S_PUSH_CHK && !present && !full)
                fill_reg <= fill_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg     <= cmd.operation;
                    ev_raw_reg <= cmd.event_req;
                    item_reg   <= {cmd.event_req, KW'(cmd.key)};
                end
            end
            S_RED1:      q_reg <= prod[RED_SH +: 12];
            S_RED2:
            begin
                item_reg[ENT_W-1 -: ID_W] <= ev_red;
                res_ev_reg     <= '0;
                res_key_reg    <= '0;
                res_status_reg <= (op_reg == OP_POP && fill_reg == '0) ? STAT_EMPTY : STAT_OK;
            end
            S_PUSH_CHK:
            begin
                pos_reg <= AW'(fill_reg);
                if (present)
                    res_status_reg <= STAT_DUP;
                else if (full)
                    res_status_reg <= STAT_FULL;
            end
            S_UP_CMP:    pos_reg <= parent;
            S_POP_GET:
            begin
                res_ev_reg  <= hp_da[ENT_W-1 -: ID_W];
                res_key_reg <= hp_da[KW-1:0];
                item_reg    <= hp_db;
                pos_reg     <= '0;
            end
            S_DN_SEL:
            begin
                child_reg <= use_b ? hp_db : hp_da;
                cpos_reg  <= use_b ? AW'(c1_w) : AW'(c_w);
            end
            S_DN_CMP:    if (!dn_stop) pos_reg <= cpos_reg;
            default: ;
        endcase
    end

    assign done                = done_reg;
    assign result.popped_event = res_ev_reg;
    assign result.popped_key   = IN_KEY_W'($signed(res_key_reg));
    assign result.status       = res_status_reg;
    assign result.occupancy    = OCC_W'(fill_reg);

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= CW'(EVENT_SLOTS))
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPL(a_empty_pop, clk, rst_n, done && result.status == STAT_EMPTY, result.popped_event == '0 && result.occupancy == '0)
    `ASSERT_IMPL(a_clear, clk, rst_n, accept && cmd.operation == OP_CLEAR, ##3 (done && result.occupancy == '0))

endmodule

### dv/heap_checker.sv
// Checker: predicts indexed event min-heap results and compares them with the block's output.
module heap_checker
    import iemh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_item_t    cmd,
    input  logic        done,
    input  out_item_t   result,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    logic [10:0]        slot_ev [EVENT_SLOTS_D];
    logic [10:0]        pos_of  [EVENT_SLOTS_D];
    logic signed [31:0] ev_key  [EVENT_SLOTS_D];
    bit                 held    [EVENT_SLOTS_D];
    int                 fill;
    logic [7:0]         tol;
    out_item_t          expected_q[$];

    function automatic bit ranks_first(logic [10:0] a, logic [10:0] b);
        longint ka, kb, d;
        ka = ev_key[a];
        kb = ev_key[b];
        d = (ka >= kb) ? ka - kb : kb - ka;
        if (d > longint'(tol))
            return ka < kb;
        return !a[0] && b[0];
    endfunction

    task automatic swap_pos(int i, int j);
        logic [10:0] ei, ej;
        ei = slot_ev[i];
        ej = slot_ev[j];
        slot_ev[i] = ej;
        slot_ev[j] = ei;
        pos_of[ej] = 11'(i);
        pos_of[ei] = 11'(j);
    endtask

    task automatic apply_cmd(in_item_t c, output out_item_t r);
        int j, p, i, ch;
        logic [10:0] ev, last;
        r = '0;
        ev = c.event_req;
        case (c.operation)
            OP_PUSH:
            begin
                if (held[ev])
                    r.status = STAT_DUP;
                else if (fill >= EVENT_SLOTS_D)
                    r.status = STAT_FULL;
                else
                begin
                    ev_key[ev] = c.key;
                    held[ev] = 1;
                    slot_ev[fill] = ev;
                    pos_of[ev] = 11'(fill);
                    fill++;
                    j = fill - 1;
                    while (j > 0)
                    begin
                        p = (j - 1) >> 1;
                        if (ranks_first(slot_ev[p], slot_ev[j]))
                            break;
                        swap_pos(p, j);
                        j = p;
                    end
                end
            end
            OP_POP:
            begin
                if (fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.popped_event = slot_ev[0];
                    r.popped_key = ev_key[slot_ev[0]];
                    held[slot_ev[0]] = 0;
                    fill--;
                    if (fill > 0)
                    begin
                        last = slot_ev[fill];
                        slot_ev[0] = last;
                        pos_of[last] = '0;
                        i = 0;
                        forever
                        begin
                            ch = 2 * i + 1;
                            if (ch >= fill)
                                break;
                            if (ch + 1 < fill && ranks_first(slot_ev[ch + 1], slot_ev[ch]))
                                ch++;
                            if (!ranks_first(slot_ev[ch], slot_ev[i]))
                                break;
                            swap_pos(i, ch);
                            i = ch;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                foreach (held[k])
                    held[k] = 0;
                fill = 0;
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(fill);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r, got;
        if (!rst_n)
        begin
            foreach (held[k])
                held[k] = 0;
            fill = 0;
            tol = 0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            got = result;
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", exp_r, got);
                    end
                end
            end
            if (start && !busy)
            begin
                apply_cmd(cmd, exp_r);
                expected_q.push_back(exp_r);
            end
            if (cfg_we)
                tol = cfg_data;
        end
        pending = expected_q.size();
    end
endmodule

### dv/tb.sv
// Testbench top: drives heap commands and tolerance settings, reports the verdict.
module tb;
    import iemh_pkg::*;

    localparam int WATCH_LIMIT = 200000;
    localparam int FILL_N      = 256;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_item_t   cmd;
    logic       done;
    out_item_t  result;
    logic       cfg_we;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         idle_pct;
    int         quiet;
    bit         ev_used [EVENT_SLOTS_D];

    indexed_event_min_heap_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    heap_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // start stays high after an accept until the next item or an idle cycle
    task automatic send(logic [1:0] op, logic [10:0] ev, logic [31:0] k);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        cmd <= '{operation: op, event_req: ev, key: k};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_tol(logic [7:0] v);
        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_key(int spread);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(spread);
            2: return -$urandom_range(spread);
            default: return $urandom_range(3) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic random_phase(int n, int spread);
        int r;
        logic [10:0] ev;
        repeat (n)
        begin
            r = $urandom_range(99);
            ev = $urandom_range(7) == 0 ? 11'($urandom) : 11'($urandom_range(63));
            if (r < 52)
                send(OP_PUSH, ev, rand_key(spread));
            else if (r < 94)
                send(OP_POP, 11'($urandom), $urandom);
            else if (r < 97)
                send(OP_CLEAR, 11'($urandom), $urandom);
            else
                send(OP_NOP, 11'($urandom), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 0;
        start = 0;
        cmd = '0;
        cfg_we = 0;
        cfg_data = 0;
        quiet = 0;
        idle_pct = 7;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(OP_POP, 11'h7ff, 32'hffff_ffff);
        send(OP_PUSH, 11'd0, 32'h7fff_ffff);
        send(OP_PUSH, 11'h7ff, 32'h8000_0000);
        send(OP_PUSH, 11'h7ff, 32'd5);
        send(OP_PUSH, 11'd2, 32'd10);
        send(OP_PUSH, 11'd3, 32'd10);
        send(OP_PUSH, 11'd5, 32'd0);
        send(OP_PUSH, 11'd4, 32'd0);
        send(OP_NOP, 11'd9, 32'd1);
        repeat (7) send(OP_POP, 11'd0, 32'd0);
        send(OP_PUSH, 11'd7, 32'd1);
        send(OP_CLEAR, 11'd0, 32'd0);
        send(OP_POP, 11'd0, 32'd0);

        set_tol(8'd255);
        send(OP_PUSH, 11'd11, 32'd0);
        send(OP_PUSH, 11'd10, 32'd200);
        send(OP_PUSH, 11'd13, -32'sd255);
        send(OP_PUSH, 11'd12, 32'd256);
        repeat (4) send(OP_POP, 11'd0, 32'd0);

        // deep heap with high ids, duplicate push, then partial drain
        set_tol(8'd0);
        idle_pct = 0;
        send(OP_PUSH, 11'd6, 32'd0);
        for (int i = 0; i < FILL_N; i++)
            send(OP_PUSH, 11'(i) ^ 11'h7ff, rand_key(1000));
        send(OP_PUSH, 11'd6, 32'd0);
        repeat (40) send(OP_POP, 11'd0, 32'd0);
        send(OP_CLEAR, 11'd0, 32'd0);

        idle_pct = 7;
        set_tol(8'd3);
        random_phase(320, 20);
        idle_pct = 83;
        set_tol(8'd128);
        random_phase(320, 400);
        idle_pct = 0;
        set_tol(8'd0);
        random_phase(330, 50);

        start <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
